### rtl/dll_pkg.sv
// Shared types, constants and helpers for the array-backed doubly linked list.
package dll_pkg;

   // Store geometry: slot numbers and links travel in fixed-width fields
   localparam int SLOT_COUNT  = 16;
   localparam int IDX_W       = $clog2(SLOT_COUNT);
   localparam int SLOT_W      = 4;
   localparam int LINK_W      = 5;
   localparam int REC_W       = 64;
   localparam int RECORD_BITS_DEF = 64;

   // Link value that marks "no slot"
   localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(SLOT_COUNT);

   typedef enum logic [2:0] {
      CMD_ADD_FIRST = 3'd0,
      CMD_ADD_LAST  = 3'd1,
      CMD_ADD_AFTER = 3'd2,
      CMD_DEL_FIRST = 3'd3,
      CMD_DEL_LAST  = 3'd4,
      CMD_DEL_AFTER = 3'd5,
      CMD_CLEAR     = 3'd6,
      CMD_READ_SLOT = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_BAD     = 3'd3,
      ST_NOAFTER = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [SLOT_W-1:0] slot;
      logic [REC_W-1:0]  record;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [LINK_W-1:0] slot_used;
      logic [LINK_W-1:0] count;
      logic [LINK_W-1:0] head;
      logic [LINK_W-1:0] tail;
      logic [REC_W-1:0]  read_record;
      logic [LINK_W-1:0] read_prev;
      logic [LINK_W-1:0] read_next;
   } rsp_type;

   // Strip a link down to a store index
   function automatic logic [IDX_W-1:0] to_idx(input logic [LINK_W-1:0] s);
      return s[IDX_W-1:0];
   endfunction

endpackage

### rtl/array_doubly_linked_list.sv
// Top level: command register, list core and result register.
// Doubly linked list in a store of 16 slots. One command is taken per clock:
// start is sampled with busy low, the command is registered, decoded against
// the list in the following cycle, and its result is registered and appears
// on rsp_data with rsp_valid high for exactly one cycle. The result cannot be
// held off, so capture it when rsp_valid is high. Busy is high only while
// reset is asserted; otherwise a new command may be issued in every cycle,
// and each command sees the list as left by the one before it. Slot allocation
// uses a priority encoder over the in-use flags, so every command is handled
// in a single combinational pass.
module array_doubly_linked_list #(
   parameter int RECORD_BITS = dll_pkg::RECORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dll_pkg::req_type req_data,
   output logic             rsp_valid,
   output dll_pkg::rsp_type rsp_data
);
   import dll_pkg::*;

   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign busy = reset;

   // Capture the command beat
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   dll_core #(
      .RECORD_BITS (RECORD_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .go    (req_valid_ff),
      .req   (req_ff),
      .rsp   (rsp_in)
   );

   // Register the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/dll_free_enc.sv
// Priority encoder that finds the lowest-numbered free slot.
module dll_free_enc (
   input  logic [dll_pkg::SLOT_COUNT-1:0] in_use,
   output logic [dll_pkg::LINK_W-1:0]     free_slot
);
   import dll_pkg::*;

   // Scan from the top so the lowest free slot wins
   always_comb begin
      free_slot = NONE_SLOT;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!in_use[i]) begin
            free_slot = LINK_W'(i);
         end
      end
   end

endmodule

### rtl/dll_core.sv
// List state registers and the single-pass command logic.
module dll_core #(
   parameter int RECORD_BITS = dll_pkg::RECORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  dll_pkg::req_type req,
   output dll_pkg::rsp_type rsp
);
   import dll_pkg::*;

   logic [LINK_W-1:0]      next_ff [SLOT_COUNT];
   logic [LINK_W-1:0]      next_in [SLOT_COUNT];
   logic [LINK_W-1:0]      prev_ff [SLOT_COUNT];
   logic [LINK_W-1:0]      prev_in [SLOT_COUNT];
   logic [RECORD_BITS-1:0] pay_ff  [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  in_use_ff, in_use_in;
   logic [LINK_W-1:0]      head_ff, head_in;
   logic [LINK_W-1:0]      tail_ff, tail_in;
   logic [LINK_W-1:0]      count_ff, count_in;

   logic [LINK_W-1:0]      free_slot;
   logic [IDX_W-1:0]       ref_idx;
   logic                   ref_ok;
   logic                   pay_we;
   logic [LINK_W-1:0]      at_slot;
   logic [LINK_W-1:0]      add_q;
   logic                   do_unlink;
   logic [LINK_W-1:0]      del_n;
   logic [LINK_W-1:0]      del_p;
   logic [LINK_W-1:0]      del_q;

   dll_free_enc u_free_enc (
      .in_use    (in_use_ff),
      .free_slot (free_slot)
   );

   assign ref_idx = req.slot[IDX_W-1:0];
   assign ref_ok  = (LINK_W'(req.slot) < NONE_SLOT) && in_use_ff[ref_idx];

   // Decode one command against the current list
   always_comb begin
      next_in   = next_ff;
      prev_in   = prev_ff;
      in_use_in = in_use_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      pay_we    = 1'b0;
      at_slot   = NONE_SLOT;
      add_q     = NONE_SLOT;
      do_unlink = 1'b0;
      del_n     = NONE_SLOT;
      del_p     = NONE_SLOT;
      del_q     = NONE_SLOT;

      rsp             = '0;
      rsp.status      = ST_OK;
      rsp.slot_used   = NONE_SLOT;
      rsp.read_prev   = NONE_SLOT;
      rsp.read_next   = NONE_SLOT;

      unique case (req.cmd)
         CMD_ADD_FIRST, CMD_ADD_LAST, CMD_ADD_AFTER: begin
            if (free_slot == NONE_SLOT) begin
               rsp.status = ST_FULL;
            end else if (req.cmd == CMD_ADD_AFTER && !ref_ok) begin
               rsp.status = ST_BAD;
            end else begin
               if (req.cmd == CMD_ADD_LAST) begin
                  at_slot = tail_ff;
               end else if (req.cmd == CMD_ADD_AFTER) begin
                  at_slot = LINK_W'(req.slot);
               end
               pay_we                      = 1'b1;
               in_use_in[to_idx(free_slot)] = 1'b1;
               count_in                    = count_ff + LINK_W'(1);
               rsp.slot_used               = free_slot;
               if (at_slot == NONE_SLOT) begin
                  // link at the front
                  prev_in[to_idx(free_slot)] = NONE_SLOT;
                  next_in[to_idx(free_slot)] = head_ff;
                  if (head_ff != NONE_SLOT) begin
                     prev_in[to_idx(head_ff)] = free_slot;
                  end else begin
                     tail_in = free_slot;
                  end
                  head_in = free_slot;
               end else begin
                  // link behind the reference slot
                  add_q                      = next_ff[to_idx(at_slot)];
                  prev_in[to_idx(free_slot)] = at_slot;
                  next_in[to_idx(free_slot)] = add_q;
                  next_in[to_idx(at_slot)]   = free_slot;
                  if (add_q != NONE_SLOT) begin
                     prev_in[to_idx(add_q)] = free_slot;
                  end else begin
                     tail_in = free_slot;
                  end
               end
            end
         end
         CMD_DEL_FIRST, CMD_DEL_LAST: begin
            del_n = (req.cmd == CMD_DEL_FIRST) ? head_ff : tail_ff;
            if (del_n == NONE_SLOT) begin
               rsp.status = ST_EMPTY;
            end else begin
               do_unlink = 1'b1;
            end
         end
         CMD_DEL_AFTER: begin
            if (!ref_ok) begin
               rsp.status = ST_BAD;
            end else begin
               del_n = next_ff[ref_idx];
               if (del_n == NONE_SLOT) begin
                  rsp.status = ST_NOAFTER;
               end else begin
                  do_unlink = 1'b1;
               end
            end
         end
         CMD_CLEAR: begin
            in_use_in = '0;
            head_in   = NONE_SLOT;
            tail_in   = NONE_SLOT;
            count_in  = '0;
         end
         CMD_READ_SLOT: begin
            if (!ref_ok) begin
               rsp.status = ST_BAD;
            end else begin
               rsp.slot_used   = LINK_W'(req.slot);
               rsp.read_record = REC_W'(pay_ff[ref_idx]);
               rsp.read_prev   = prev_ff[ref_idx];
               rsp.read_next   = next_ff[ref_idx];
            end
         end
         default: begin
            rsp.status = ST_BAD;
         end
      endcase

      // Splice the removed slot out of the chain
      if (do_unlink) begin
         del_p = prev_ff[to_idx(del_n)];
         del_q = next_ff[to_idx(del_n)];
         if (del_p != NONE_SLOT) begin
            next_in[to_idx(del_p)] = del_q;
         end else begin
            head_in = del_q;
         end
         if (del_q != NONE_SLOT) begin
            prev_in[to_idx(del_q)] = del_p;
         end else begin
            tail_in = del_p;
         end
         in_use_in[to_idx(del_n)] = 1'b0;
         if (count_ff != '0) begin
            count_in = count_ff - LINK_W'(1);
         end
         rsp.slot_used = del_n;
      end

      rsp.count = count_in;
      rsp.head  = head_in;
      rsp.tail  = tail_in;
   end

   // Hold list control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         head_ff   <= NONE_SLOT;
         tail_ff   <= NONE_SLOT;
         count_ff  <= '0;
      end else if (go) begin
         in_use_ff <= in_use_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
      end
   end

   // Advance links and payload; these need no reset
   always_ff @(posedge clock) begin
      if (go) begin
         next_ff <= next_in;
         prev_ff <= prev_in;
         if (pay_we) begin
            pay_ff[to_idx(free_slot)] <= req.record[RECORD_BITS-1:0];
         end
      end
   end

endmodule

### rtl/dll_checker.sv
// Port-level checks for the linked list block, bound to the top level.
module dll_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input dll_pkg::req_type req_data,
   input logic             rsp_valid,
   input dll_pkg::rsp_type rsp_data
);
   import dll_pkg::*;

   // Every accepted beat yields exactly one result, passed on through the command and result registers
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(reset, 2)) |-> (rsp_valid == $past(start && !busy, 2)))
      else $error("result strobe does not follow accepted command");

   // An empty list has no head and no tail, and a non-empty one has both
   a_ends_match_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_data.head == NONE_SLOT) == (rsp_data.count == '0)) &&
                     ((rsp_data.tail == NONE_SLOT) == (rsp_data.count == '0))))
      else $error("head or tail disagree with count");

   // Count never exceeds the store size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.count <= LINK_W'(SLOT_COUNT)))
      else $error("count out of range");

   // A failed command reports no slot and no read data
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.slot_used == NONE_SLOT && rsp_data.read_record == '0 &&
          rsp_data.read_prev == NONE_SLOT && rsp_data.read_next == NONE_SLOT))
      else $error("failed command carries slot or read data");

endmodule

bind array_doubly_linked_list dll_checker u_dll_checker (.*);

### tb/sv/dll_list_checker.sv
// Checker for the linked-list block: mirrors the list, predicts each result and compares.
`timescale 1ns / 1ps

module dll_list_checker
   import dll_pkg::*;
#(
   parameter int RECORD_BITS = RECORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   localparam logic [REC_W-1:0] REC_MASK =
      (RECORD_BITS >= REC_W) ? '1 : ((64'd1 << RECORD_BITS) - 64'd1);

   // Mirror of the list store
   logic [LINK_W-1:0] fwd_link [SLOT_COUNT];
   logic [LINK_W-1:0] back_link [SLOT_COUNT];
   logic [REC_W-1:0]  stored_rec [SLOT_COUNT];
   bit                occupied [SLOT_COUNT];
   logic [LINK_W-1:0] first_slot;
   logic [LINK_W-1:0] last_slot;
   logic [LINK_W-1:0] entries;

   rsp_type expected_q[$];

   initial begin
      failures = 0;
      pending = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         fwd_link[i] = NONE_SLOT;
         back_link[i] = NONE_SLOT;
         stored_rec[i] = '0;
         occupied[i] = 0;
      end
      first_slot = NONE_SLOT;
      last_slot = NONE_SLOT;
      entries = '0;
   end

   // Lowest-numbered free slot, or none when the store is full
   function automatic logic [LINK_W-1:0] lowest_free_slot();
      for (int i = 0; i < SLOT_COUNT; i++)
         if (!occupied[i])
            return LINK_W'(i);
      return NONE_SLOT;
   endfunction

   // Place fresh slot n after anchor; no anchor means the front
   function automatic void link_in(logic [LINK_W-1:0] anchor, logic [LINK_W-1:0] n,
                                   logic [REC_W-1:0] rec);
      logic [LINK_W-1:0] succ;
      stored_rec[to_idx(n)] = rec & REC_MASK;
      occupied[to_idx(n)] = 1;
      entries++;
      if (anchor == NONE_SLOT) begin
         back_link[to_idx(n)] = NONE_SLOT;
         fwd_link[to_idx(n)] = first_slot;
         if (first_slot != NONE_SLOT)
            back_link[to_idx(first_slot)] = n;
         else
            last_slot = n;
         first_slot = n;
      end else begin
         succ = fwd_link[to_idx(anchor)];
         back_link[to_idx(n)] = anchor;
         fwd_link[to_idx(n)] = succ;
         fwd_link[to_idx(anchor)] = n;
         if (succ != NONE_SLOT)
            back_link[to_idx(succ)] = n;
         else
            last_slot = n;
      end
   endfunction

   function automatic void unlink(logic [LINK_W-1:0] n);
      logic [LINK_W-1:0] pred;
      logic [LINK_W-1:0] succ;
      pred = back_link[to_idx(n)];
      succ = fwd_link[to_idx(n)];
      if (pred != NONE_SLOT)
         fwd_link[to_idx(pred)] = succ;
      else
         first_slot = succ;
      if (succ != NONE_SLOT)
         back_link[to_idx(succ)] = pred;
      else
         last_slot = pred;
      occupied[to_idx(n)] = 0;
      if (entries != 0)
         entries--;
   endfunction

   // Apply one command to the mirror and return the result it should produce
   function automatic rsp_type apply_command(req_type r);
      rsp_type o;
      logic [LINK_W-1:0] n;
      logic [LINK_W-1:0] anchor;
      o = '0;
      o.status = ST_OK;
      o.slot_used = NONE_SLOT;
      o.read_prev = NONE_SLOT;
      o.read_next = NONE_SLOT;
      case (r.cmd)
         CMD_ADD_FIRST, CMD_ADD_LAST, CMD_ADD_AFTER: begin
            n = lowest_free_slot();
            if (n == NONE_SLOT) begin
               o.status = ST_FULL;
            end else if (r.cmd == CMD_ADD_AFTER && !occupied[r.slot]) begin
               o.status = ST_BAD;
            end else begin
               if (r.cmd == CMD_ADD_FIRST)
                  anchor = NONE_SLOT;
               else if (r.cmd == CMD_ADD_LAST)
                  anchor = last_slot;
               else
                  anchor = LINK_W'(r.slot);
               link_in(anchor, n, r.record);
               o.slot_used = n;
            end
         end
         CMD_DEL_FIRST, CMD_DEL_LAST: begin
            n = (r.cmd == CMD_DEL_FIRST) ? first_slot : last_slot;
            if (n == NONE_SLOT) begin
               o.status = ST_EMPTY;
            end else begin
               unlink(n);
               o.slot_used = n;
            end
         end
         CMD_DEL_AFTER: begin
            if (!occupied[r.slot]) begin
               o.status = ST_BAD;
            end else if (fwd_link[r.slot] == NONE_SLOT) begin
               o.status = ST_NOAFTER;
            end else begin
               n = fwd_link[r.slot];
               unlink(n);
               o.slot_used = n;
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               occupied[i] = 0;
            first_slot = NONE_SLOT;
            last_slot = NONE_SLOT;
            entries = '0;
         end
         default: begin
            if (!occupied[r.slot]) begin
               o.status = ST_BAD;
            end else begin
               o.slot_used = LINK_W'(r.slot);
               o.read_record = stored_rec[r.slot];
               o.read_prev = back_link[r.slot];
               o.read_next = fwd_link[r.slot];
            end
         end
      endcase
      o.count = entries;
      o.head = first_slot;
      o.tail = last_slot;
      return o;
   endfunction

   // Count every failure, print only the first few
   function automatic void flag_error(string msg);
      failures++;
      if (failures <= 10)
         $display("%0t ns: %s", $time, msg);
   endfunction

   // Retire results against the oldest prediction, then predict the new beat
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_q.size() == 0) begin
               flag_error($sformatf("result with nothing expected: %p", rsp_data));
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.slot_used !== want.slot_used ||
                   rsp_data.count !== want.count || rsp_data.head !== want.head ||
                   rsp_data.tail !== want.tail || rsp_data.read_record !== want.read_record ||
                   rsp_data.read_prev !== want.read_prev ||
                   rsp_data.read_next !== want.read_next)
                  flag_error($sformatf({"mismatch (expected/actual): status %0d/%0d ",
                     "slot %0d/%0d count %0d/%0d head %0d/%0d tail %0d/%0d ",
                     "record %h/%h prev %0d/%0d next %0d/%0d"},
                     want.status, rsp_data.status, want.slot_used, rsp_data.slot_used,
                     want.count, rsp_data.count, want.head, rsp_data.head,
                     want.tail, rsp_data.tail, want.read_record, rsp_data.read_record,
                     want.read_prev, rsp_data.read_prev, want.read_next, rsp_data.read_next));
            end
         end else if (rsp_valid !== 1'b0) begin
            flag_error("result strobe is unknown");
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_q.push_back(apply_command(req_data));
      end
      pending <= expected_q.size();
   end

endmodule

### tb/sv/testbench.sv
// Top of the linked-list testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import dll_pkg::*;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_CHURN
   } mix_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      beats_sent;

   array_doubly_linked_list dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   dll_list_checker list_check (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #200000;
      $display("== FAIL ==");
      $finish;
   end

   // Mostly random payloads, with the all-zero and all-one corners now and then
   function automatic logic [REC_W-1:0] rand_record();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   // Bias the command mix so the list swings between empty and full
   function automatic cmd_type pick_command(mix_type m);
      int add_pct;
      int del_pct;
      int r;
      add_pct = (m == MIX_FILL) ? 65 : (m == MIX_DRAIN) ? 20 : 40;
      del_pct = (m == MIX_FILL) ? 20 : (m == MIX_DRAIN) ? 65 : 40;
      r = $urandom_range(99);
      if (r < add_pct)
         return cmd_type'($urandom_range(2));
      if (r < add_pct + del_pct)
         return cmd_type'(3 + $urandom_range(2));
      if (r == 99)
         return CMD_CLEAR;
      return CMD_READ_SLOT;
   endfunction

   // Present one beat, hold it until accepted, then maybe idle a little
   task automatic send(cmd_type c, logic [SLOT_W-1:0] s, logic [REC_W-1:0] rec);
      req_data <= '{cmd: c, slot: s, record: rec};
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      beats_sent++;
      if ((beats_sent < 700 || beats_sent >= 1100) && $urandom_range(99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   initial begin
      mix_type mode;
      beats_sent = 0;
      mode = MIX_FILL;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list and bad references
      send(CMD_DEL_FIRST, 4'd0, '0);
      send(CMD_DEL_LAST, 4'd0, '0);
      send(CMD_DEL_AFTER, 4'd5, '0);
      send(CMD_READ_SLOT, 4'd3, '0);
      send(CMD_ADD_AFTER, 4'd0, '1);
      // Add at the back of an empty list, then at the front and after slot 0, the tail
      send(CMD_ADD_LAST, 4'd0, '1);
      send(CMD_ADD_FIRST, 4'd15, '0);
      send(CMD_ADD_AFTER, 4'd0, 64'hA5A5_5A5A_0F0F_F0F0);
      send(CMD_READ_SLOT, 4'd0, '0);
      send(CMD_DEL_AFTER, 4'd2, '0);
      // Fill the store, then try to add past full
      repeat (13) send(CMD_ADD_LAST, 4'($urandom_range(15)), rand_record());
      send(CMD_ADD_FIRST, 4'd0, '1);
      send(CMD_ADD_AFTER, 4'd15, '1);
      send(CMD_READ_SLOT, 4'd15, '0);
      send(CMD_DEL_AFTER, 4'd1, '0);
      send(CMD_DEL_LAST, 4'd0, '0);
      send(CMD_DEL_FIRST, 4'd0, '0);
      send(CMD_CLEAR, 4'd0, '0);
      send(CMD_READ_SLOT, 4'd2, '0);

      // Random traffic in phases of filling, draining and churning
      for (int k = 0; k < 1650; k++) begin
         if (k % 40 == 0)
            mode = mix_type'($urandom_range(2));
         send(pick_command(mode), 4'($urandom_range(15)), rand_record());
      end
      start <= 1'b0;

      // Drain outstanding results, then allow for stray ones
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
